// ----- src/keyed_record_table_engine_defines.svh -----
// assertion macros for the keyed record table engine
// depends on nothing; included by the top level
`ifndef KEYED_RECORD_TABLE_ENGINE_DEFINES_SVH
`define KEYED_RECORD_TABLE_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define KRTE_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define KRTE_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define KRTE_ASSERT_IMP(label, clk, rst, pre, post)
`define KRTE_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

// ----- src/krte_pkg.sv -----
// types and codes for the keyed record table engine
// depends on nothing
package krte_pkg;

   localparam logic [2:0] REQ_APPEND = 3'd0;
   localparam logic [2:0] REQ_DELETE = 3'd1;
   localparam logic [2:0] REQ_FIND   = 3'd2;
   localparam logic [2:0] REQ_UPDATE = 3'd3;
   localparam logic [2:0] REQ_SORT   = 3'd4;
   localparam logic [2:0] REQ_READ   = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_INVALID  = 2'd3;

   localparam logic [1:0] SEL_KEY     = 2'd0;
   localparam logic [1:0] SEL_RUNS    = 2'd1;
   localparam logic [1:0] SEL_MATCHES = 2'd2;

   localparam logic [1:0] UPD_MATCHES = 2'd0;
   localparam logic [1:0] UPD_RUNS    = 2'd1;
   localparam logic [1:0] UPD_WICKETS = 2'd2;
   localparam logic [1:0] UPD_INVALID = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [9:0]  key_number;
      logic [15:0] matches_value;
      logic [15:0] runs_value;
      logic [15:0] wickets_value;
      logic [1:0]  field_select;
      logic [15:0] new_value;
      logic [3:0]  entry_index;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  found_index;
      logic [9:0]  out_key;
      logic [15:0] out_matches;
      logic [15:0] out_runs;
      logic [15:0] out_wickets;
      logic [4:0]  record_count;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  key;
      logic [15:0] matches_count;
      logic [15:0] runs;
      logic [15:0] wickets;
   } record_type;

endpackage

// ----- src/keyed_record_table_engine.sv -----
// keyed record table engine top level: record memory and sequencer
// depends on krte_pkg and keyed_record_table_engine_defines.svh
`include "keyed_record_table_engine_defines.svh"

// Keeps up to TABLE_CAPACITY records in one single-port-read memory with a
// registered read. Pulse start with busy low; busy stays high until the single
// result is shown on rsp_* with rsp_valid for exactly one cycle, which must
// be taken then. Find, update and delete search the entries in order from the
// first; delete then shifts every later entry down by one. Sort holds each
// entry in turn and compares it with every later entry, swapping where the
// held one is larger, so the table ends up in ascending order.
module keyed_record_table_engine #(
   parameter int TABLE_CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  krte_pkg::req_type_type  req_item,
   output logic                    rsp_valid,
   output krte_pkg::rsp_type       rsp_item
);

   localparam int AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
   localparam int CW = $clog2(TABLE_CAPACITY + 1);
   localparam logic [CW-1:0] CAP = CW'(TABLE_CAPACITY);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_SRCH   = 10'b0000000010,
      S_SCHK   = 10'b0000000100,
      S_SHRD   = 10'b0000001000,
      S_SHWR   = 10'b0000010000,
      S_RDI    = 10'b0000100000,
      S_RDJ    = 10'b0001000000,
      S_CMP    = 10'b0010000000,
      S_RDOUT  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   krte_pkg::req_type_type req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   krte_pkg::record_type reci_ff, reci_in;
   krte_pkg::rsp_type rsp_ff, rsp_in;
   logic valid_ff, valid_in;

   // record memory, read data registered
   krte_pkg::record_type mem [TABLE_CAPACITY];
   krte_pkg::record_type rd_data_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;
   krte_pkg::record_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   function automatic logic [15:0] field_of(krte_pkg::record_type r, logic [1:0] s);
      case (s)
         krte_pkg::SEL_KEY:     field_of = {6'd0, r.key};
         krte_pkg::SEL_RUNS:    field_of = r.runs;
         krte_pkg::SEL_MATCHES: field_of = r.matches_count;
         default:               field_of = r.wickets;
      endcase
   endfunction

   function automatic krte_pkg::rsp_type mk(logic [1:0] st, logic [CW-1:0] pos,
                                            krte_pkg::record_type r, logic show,
                                            logic [CW-1:0] cnt);
      krte_pkg::rsp_type o;
      o = '0;
      o.status = st;
      if (show) begin
         o.found_index = 4'(pos);
         o.out_key = r.key;
         o.out_matches = r.matches_count;
         o.out_runs = r.runs;
         o.out_wickets = r.wickets;
      end
      o.record_count = 5'(cnt);
      return o;
   endfunction

   krte_pkg::record_type app_rec, upd_rec;

   // sequencer
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      count_in = count_ff;
      i_in = i_ff;
      j_in = j_ff;
      reci_in = reci_ff;
      rsp_in = rsp_ff;
      valid_in = 1'b0;
      rd_addr = AW'(i_ff);
      wr_en = 1'b0;
      wr_addr = AW'(i_ff);
      wr_data = rd_data_ff;
      app_rec.key = req_ff.key_number;
      app_rec.matches_count = req_ff.matches_value;
      app_rec.runs = req_ff.runs_value;
      app_rec.wickets = req_ff.wickets_value;
      upd_rec = rd_data_ff;
      case (req_ff.field_select)
         krte_pkg::UPD_MATCHES: upd_rec.matches_count = req_ff.new_value;
         krte_pkg::UPD_RUNS:    upd_rec.runs = req_ff.new_value;
         default:               upd_rec.wickets = req_ff.new_value;
      endcase
      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               req_in = req_item;
               i_in = '0;
               state_in = S_SRCH;
               unique case (req_item.req_type) inside
                  krte_pkg::REQ_APPEND: state_in = S_DONE;
                  krte_pkg::REQ_SORT:   state_in = S_RDI;
                  krte_pkg::REQ_READ: begin
                     // out of range index parks at the count so the read fails
                     if (int'(req_item.entry_index) >= int'(count_ff)) begin
                        i_in = count_ff;
                     end else begin
                        i_in = CW'(req_item.entry_index);
                     end
                     state_in = S_RDOUT;
                  end
                  krte_pkg::REQ_DELETE, krte_pkg::REQ_FIND,
                  krte_pkg::REQ_UPDATE: state_in = S_SRCH;
                  default: state_in = S_DONE;
               endcase
            end
         end
         // search: issue read of entry i, or give up at end
         S_SRCH: begin
            if (i_ff >= count_ff) begin
               rsp_in = mk(krte_pkg::ST_NOTFOUND, '0, app_rec, 1'b0, count_ff);
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_SCHK;
            end
         end
         S_SCHK: begin
            if (rd_data_ff.key == req_ff.key_number) begin
               case (req_ff.req_type)
                  krte_pkg::REQ_FIND: begin
                     rsp_in = mk(krte_pkg::ST_OK, i_ff, rd_data_ff, 1'b1, count_ff);
                     valid_in = 1'b1;
                     state_in = S_IDLE;
                  end
                  krte_pkg::REQ_UPDATE: begin
                     if (req_ff.field_select == krte_pkg::UPD_INVALID) begin
                        rsp_in = mk(krte_pkg::ST_INVALID, '0, app_rec, 1'b0, count_ff);
                     end else begin
                        wr_en = 1'b1;
                        wr_data = upd_rec;
                        rsp_in = mk(krte_pkg::ST_OK, i_ff, upd_rec, 1'b1, count_ff);
                     end
                     valid_in = 1'b1;
                     state_in = S_IDLE;
                  end
                  default: begin
                     count_in = count_ff - 1'b1;
                     rsp_in = mk(krte_pkg::ST_OK, i_ff, rd_data_ff, 1'b1,
                                 count_ff - 1'b1);
                     j_in = i_ff + 1'b1;
                     rd_addr = AW'(i_ff + 1'b1);
                     state_in = S_SHRD;
                  end
               endcase
            end else begin
               i_in = i_ff + 1'b1;
               rd_addr = AW'(i_ff + 1'b1);
               state_in = S_SRCH;
            end
         end
         // delete shift: entry j moves to j-1
         S_SHRD: begin
            if (j_ff >= count_ff + 1'b1) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr = AW'(j_ff);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wr_en = 1'b1;
            wr_addr = AW'(j_ff - 1'b1);
            wr_data = rd_data_ff;
            j_in = j_ff + 1'b1;
            rd_addr = AW'(j_ff + 1'b1);
            state_in = S_SHRD;
         end
         // sort: hold entry i, stream entries j
         S_RDI: begin
            if (i_ff + 1'b1 >= count_ff || i_ff >= count_ff) begin
               rsp_in = mk(krte_pkg::ST_OK, '0, app_rec, 1'b0, count_ff);
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr = AW'(i_ff);
               j_in = i_ff + 1'b1;
               state_in = S_RDJ;
            end
         end
         S_RDJ: begin
            if (j_ff == i_ff + 1'b1) begin
               reci_in = rd_data_ff;
            end
            if (j_ff >= count_ff) begin
               wr_en = 1'b1;
               wr_addr = AW'(i_ff);
               wr_data = (j_ff == i_ff + 1'b1) ? rd_data_ff : reci_ff;
               i_in = i_ff + 1'b1;
               state_in = S_RDI;
            end else begin
               rd_addr = AW'(j_ff);
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (field_of(reci_ff, req_ff.field_select) >
                field_of(rd_data_ff, req_ff.field_select)) begin
               wr_en = 1'b1;
               wr_addr = AW'(j_ff);
               wr_data = reci_ff;
               reci_in = rd_data_ff;
            end
            j_in = j_ff + 1'b1;
            state_in = S_RDJ;
         end
         // read entry: issue the read, then answer
         S_RDOUT: begin
            if (i_ff >= count_ff) begin
               rsp_in = mk(krte_pkg::ST_INVALID, '0, app_rec, 1'b0, count_ff);
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DONE;
            end
         end
         // append, unknown request, read data return
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
            if (req_ff.req_type == krte_pkg::REQ_APPEND) begin
               if (count_ff >= CAP) begin
                  rsp_in = mk(krte_pkg::ST_FULL, '0, app_rec, 1'b0, count_ff);
               end else begin
                  wr_en = 1'b1;
                  wr_addr = AW'(count_ff);
                  wr_data = app_rec;
                  count_in = count_ff + 1'b1;
                  rsp_in = mk(krte_pkg::ST_OK, count_ff, app_rec, 1'b1,
                              count_ff + 1'b1);
               end
            end else if (req_ff.req_type == krte_pkg::REQ_READ) begin
               rsp_in = mk(krte_pkg::ST_OK, i_ff, rd_data_ff, 1'b1, count_ff);
            end else begin
               rsp_in = mk(krte_pkg::ST_INVALID, '0, app_rec, 1'b0, count_ff);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
      i_ff <= i_in;
      j_ff <= j_in;
      reci_ff <= reci_in;
      rsp_ff <= rsp_in;
   end

   // result stays up for one cycle; the block is busy until it is out
   assign busy = (state_ff != S_IDLE) || valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_item = rsp_ff;

   `KRTE_ASSERT_IMP(a_count_cap, clock, reset, 1'b1, count_ff <= CAP)
   `KRTE_ASSERT_NXT(a_one_pulse, clock, reset, valid_ff, !valid_ff)
   `KRTE_ASSERT_IMP(a_busy_out, clock, reset, valid_ff, busy)

endmodule

// ----- sim/keyed_record_table_engine_tb.sv -----
// self-checking testbench for the keyed record table engine
// depends on krte_pkg and the keyed_record_table_engine top level
module keyed_record_table_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = 16;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   krte_pkg::req_type_type req_item;
   logic                   rsp_valid;
   krte_pkg::rsp_type      rsp_item;

   // table shadow
   krte_pkg::record_type   shadow_table [CAP];
   int unsigned            shadow_count;
   krte_pkg::rsp_type      pending_rsp [$];
   int                     error_count;

   keyed_record_table_engine #(.TABLE_CAPACITY(CAP)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      #20ms;
      $display("keyed_record_table_engine_tb: done, errors");
      $finish;
   end

   function automatic logic [15:0] sort_field(krte_pkg::record_type r, logic [1:0] sel);
      case (sel)
         krte_pkg::SEL_KEY:     return {6'd0, r.key};
         krte_pkg::SEL_RUNS:    return r.runs;
         krte_pkg::SEL_MATCHES: return r.matches_count;
         default:               return r.wickets;
      endcase
   endfunction

   function automatic int key_position(logic [9:0] key);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_table[i].key == key) return i;
      return -1;
   endfunction

   function automatic krte_pkg::rsp_type shown(logic [1:0] st, int pos,
                                               krte_pkg::record_type r);
      krte_pkg::rsp_type o;
      o.status = st;
      o.found_index = pos[3:0];
      o.out_key = r.key;
      o.out_matches = r.matches_count;
      o.out_runs = r.runs;
      o.out_wickets = r.wickets;
      o.record_count = shadow_count[4:0];
      return o;
   endfunction

   function automatic krte_pkg::rsp_type blank(logic [1:0] st);
      krte_pkg::rsp_type o;
      o = '0;
      o.status = st;
      o.record_count = shadow_count[4:0];
      return o;
   endfunction

   // table engine prediction
   function automatic krte_pkg::rsp_type predict_table(krte_pkg::req_type_type q);
      int pos;
      krte_pkg::record_type r, t;
      case (q.req_type)
         krte_pkg::REQ_APPEND: begin
            if (shadow_count >= CAP) return blank(krte_pkg::ST_FULL);
            r.key = q.key_number;
            r.matches_count = q.matches_value;
            r.runs = q.runs_value;
            r.wickets = q.wickets_value;
            shadow_table[shadow_count] = r;
            shadow_count++;
            return shown(krte_pkg::ST_OK, shadow_count - 1, r);
         end
         krte_pkg::REQ_DELETE: begin
            pos = key_position(q.key_number);
            if (pos < 0) return blank(krte_pkg::ST_NOTFOUND);
            r = shadow_table[pos];
            for (int i = pos; i + 1 < shadow_count; i++)
               shadow_table[i] = shadow_table[i + 1];
            shadow_count--;
            return shown(krte_pkg::ST_OK, pos, r);
         end
         krte_pkg::REQ_FIND: begin
            pos = key_position(q.key_number);
            if (pos < 0) return blank(krte_pkg::ST_NOTFOUND);
            return shown(krte_pkg::ST_OK, pos, shadow_table[pos]);
         end
         krte_pkg::REQ_UPDATE: begin
            pos = key_position(q.key_number);
            if (pos < 0) return blank(krte_pkg::ST_NOTFOUND);
            case (q.field_select)
               krte_pkg::UPD_MATCHES: shadow_table[pos].matches_count = q.new_value;
               krte_pkg::UPD_RUNS:    shadow_table[pos].runs = q.new_value;
               krte_pkg::UPD_WICKETS: shadow_table[pos].wickets = q.new_value;
               default:               return blank(krte_pkg::ST_INVALID);
            endcase
            return shown(krte_pkg::ST_OK, pos, shadow_table[pos]);
         end
         krte_pkg::REQ_SORT: begin
            for (int i = 0; i < shadow_count; i++)
               for (int j = i + 1; j < shadow_count; j++)
                  if (sort_field(shadow_table[i], q.field_select) >
                      sort_field(shadow_table[j], q.field_select)) begin
                     t = shadow_table[i];
                     shadow_table[i] = shadow_table[j];
                     shadow_table[j] = t;
                  end
            return blank(krte_pkg::ST_OK);
         end
         krte_pkg::REQ_READ: begin
            if (q.entry_index < shadow_count)
               return shown(krte_pkg::ST_OK, q.entry_index, shadow_table[q.entry_index]);
            return blank(krte_pkg::ST_INVALID);
         end
         default: return blank(krte_pkg::ST_INVALID);
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      krte_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("result with nothing pending");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_item.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_item.status); error_count++;
            end
            if (rsp_item.found_index !== e.found_index) begin
               $error("found_index exp %0d got %0d", e.found_index, rsp_item.found_index);
               error_count++;
            end
            if (rsp_item.out_key !== e.out_key) begin
               $error("out_key exp %0d got %0d", e.out_key, rsp_item.out_key); error_count++;
            end
            if (rsp_item.out_matches !== e.out_matches) begin
               $error("out_matches exp %0d got %0d", e.out_matches, rsp_item.out_matches);
               error_count++;
            end
            if (rsp_item.out_runs !== e.out_runs) begin
               $error("out_runs exp %0d got %0d", e.out_runs, rsp_item.out_runs); error_count++;
            end
            if (rsp_item.out_wickets !== e.out_wickets) begin
               $error("out_wickets exp %0d got %0d", e.out_wickets, rsp_item.out_wickets);
               error_count++;
            end
            if (rsp_item.record_count !== e.record_count) begin
               $error("record_count exp %0d got %0d", e.record_count, rsp_item.record_count);
               error_count++;
            end
         end
      end
   end

   int burst_left;

   // send one item, with bursty gaps
   task automatic send_item(krte_pkg::req_type_type q);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(posedge clock);
      end
      burst_left--;
      req_item <= q;
      start <= 1'b1;
      // look at busy mid-cycle; the next rising edge then takes the item
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_rsp.push_back(predict_table(q));
      start <= 1'b0;
      // item taken at this edge; wait for its result before the next
      @(posedge clock);
      while (busy || pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic krte_pkg::req_type_type rand_item();
      krte_pkg::req_type_type q;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      q = raw[$bits(krte_pkg::req_type_type)-1:0];
      q.key_number = (($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 999))
                                                 : 10'($urandom_range(0, 20)));
      return q;
   endfunction

   function automatic krte_pkg::req_type_type make_req(logic [2:0] op, logic [9:0] key,
                                                       logic [1:0] sel, logic [3:0] idx);
      krte_pkg::req_type_type q;
      q = rand_item();
      q.req_type = op;
      q.key_number = key;
      q.field_select = sel;
      q.entry_index = idx;
      return q;
   endfunction

   // directed: extremes, every operation, each special case
   task automatic test_directed();
      krte_pkg::req_type_type q;
      send_item(make_req(krte_pkg::REQ_FIND, 10'd5, krte_pkg::SEL_KEY, 4'd0));
      send_item(make_req(krte_pkg::REQ_READ, 10'd0, krte_pkg::SEL_KEY, 4'd0));
      send_item(make_req(krte_pkg::REQ_SORT, 10'd0, krte_pkg::SEL_KEY, 4'd0));
      q = make_req(krte_pkg::REQ_APPEND, 10'd999, krte_pkg::SEL_KEY, 4'd0);
      q.matches_value = 16'hffff; q.runs_value = 16'hffff; q.wickets_value = 16'hffff;
      send_item(q);
      q = make_req(krte_pkg::REQ_APPEND, 10'd0, krte_pkg::SEL_KEY, 4'd0);
      q.matches_value = '0; q.runs_value = '0; q.wickets_value = '0;
      send_item(q);
      send_item(make_req(krte_pkg::REQ_APPEND, 10'd999, krte_pkg::SEL_KEY, 4'd0));
      send_item(make_req(krte_pkg::REQ_FIND, 10'd999, krte_pkg::SEL_KEY, 4'd0));
      send_item(make_req(krte_pkg::REQ_UPDATE, 10'd999, krte_pkg::UPD_RUNS, 4'd0));
      send_item(make_req(krte_pkg::REQ_UPDATE, 10'd0, krte_pkg::UPD_INVALID, 4'd0));
      send_item(make_req(krte_pkg::REQ_UPDATE, 10'd7, krte_pkg::UPD_INVALID, 4'd0));
      send_item(make_req(krte_pkg::REQ_READ, 10'd0, krte_pkg::SEL_KEY, 4'd15));
      // unknown request codes
      send_item(make_req(3'd6, 10'd0, krte_pkg::SEL_KEY, 4'd0));
      send_item(make_req(3'd7, 10'd0, krte_pkg::SEL_KEY, 4'd0));
      send_item(make_req(krte_pkg::REQ_DELETE, 10'd999, krte_pkg::SEL_KEY, 4'd0));
      send_item(make_req(krte_pkg::REQ_DELETE, 10'd5, krte_pkg::SEL_KEY, 4'd0));
      for (int i = 0; i < 15; i++)
         send_item(make_req(krte_pkg::REQ_APPEND, 10'(15 - i), krte_pkg::SEL_KEY, 4'd0));
      send_item(make_req(krte_pkg::REQ_APPEND, 10'd1, krte_pkg::SEL_KEY, 4'd0));
      for (int s = 0; s < 4; s++)
         send_item(make_req(krte_pkg::REQ_SORT, 10'd0, 2'(s), 4'd0));
      send_item(make_req(krte_pkg::REQ_READ, 10'd0, krte_pkg::SEL_KEY, 4'd15));
   endtask

   // random mix biased toward a populated table
   task automatic test_random(int n);
      krte_pkg::req_type_type q;
      for (int k = 0; k < n; k++) begin
         q = rand_item();
         case ($urandom_range(0, 9))
            0, 1, 2: q.req_type = krte_pkg::REQ_APPEND;
            3: q.req_type = krte_pkg::REQ_DELETE;
            4: q.req_type = krte_pkg::REQ_FIND;
            5: q.req_type = krte_pkg::REQ_UPDATE;
            6: q.req_type = krte_pkg::REQ_SORT;
            7, 8: q.req_type = krte_pkg::REQ_READ;
            default: q.req_type = 3'($urandom_range(0, 7));
         endcase
         if (q.req_type == krte_pkg::REQ_DELETE && $urandom_range(0, 1) == 0 &&
             shadow_count > 0)
            q.key_number = shadow_table[$urandom_range(0, shadow_count - 1)].key;
         send_item(q);
      end
   endtask

   initial begin
      error_count = 0;
      shadow_count = 0;
      burst_left = 0;
      for (int i = 0; i < CAP; i++) shadow_table[i] = '0;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1000);
      repeat (50) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("keyed_record_table_engine_tb: done, clean");
      else
         $display("keyed_record_table_engine_tb: done, errors");
      $finish;
   end
endmodule
